// ----- rtl/assert_macros.svh -----
// Assertion macros used by stable_insertion_sorter.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk outside reset.
`define SIS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition holds in the cycle after a trigger.
`define SIS_ASSERT_NEXT(label, trig, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) \
		else $error(msg);

`endif

// ----- rtl/sis_pkg.sv -----
// Package of the stable insertion sorter: store depth, field widths and types.
// Used by sis_cell, stable_insertion_sorter and the testbench; depends on nothing.
`default_nettype none

package sis_pkg;

	localparam int DEPTH       = 16;
	localparam int KEY_W       = 32;
	localparam int PAYLOAD_W   = 16;
	localparam int DATA_W      = KEY_W + PAYLOAD_W;

	typedef struct packed {
		logic [KEY_W-1:0]     key;
		logic [PAYLOAD_W-1:0] payload;
	} sis_entry_t;

	typedef struct packed {
		logic insert;
		logic drain;
	} sis_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/sis_cell.sv -----
// One slot of the insertion chain: holds a key, its payload and a valid bit.
// Depends on sis_pkg for the entry and control types.
`default_nettype none

module sis_cell
	import sis_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire sis_ctrl_t  ctrl,
	input  wire sis_entry_t new_ent,
	input  wire sis_entry_t left_ent,
	input  wire logic       left_valid,
	input  wire logic       left_moves,
	input  wire sis_entry_t right_ent,
	input  wire logic       right_valid,
	output sis_entry_t      ent,
	output logic            valid,
	output logic            moves
);

	sis_entry_t ent_q;
	logic       valid_q;
	logic       greater;

	// An empty slot behaves as if it held a key above every input key.
	assign greater = valid_q && ($signed(ent_q.key) > $signed(new_ent.key));
	assign moves   = !valid_q || greater;
	assign ent     = ent_q;
	assign valid   = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.drain) begin
			valid_q <= right_valid;
		end else if (ctrl.insert) begin
			valid_q <= valid_q | left_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.drain) begin
			ent_q <= right_ent;
		end else if (ctrl.insert && moves) begin
			ent_q <= left_moves ? left_ent : new_ent;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/stable_insertion_sorter.sv -----
// Stable insertion sorter: a chain of DEPTH cells kept in ascending key order.
// Accepts one pair per cycle unless draining; each is inserted as it is taken, or dropped
// and flagged if the chain is full. After the end-marked pair, the set drains from cell 0
// at one result per cycle while m_axis_tready is high, starting in the next cycle.
// Reset (arst_n low, asynchronous) empties the chain and clears the overflow flag.
// Depends on sis_pkg, sis_cell and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module stable_insertion_sorter
	import sis_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [DATA_W-1:0] s_axis_tdata,  // sort_key[31:0], payload[47:32]
	input  wire logic              s_axis_tlast,
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [DATA_W-1:0]      m_axis_tdata,  // out_key[31:0], out_payload[47:32]
	output logic                   m_axis_tlast,
	output logic                   m_axis_tuser   // overflowed
);

	sis_entry_t       cell_ent   [DEPTH];
	logic [DEPTH-1:0] cell_valid;
	logic [DEPTH-1:0] cell_moves;
	sis_entry_t       new_ent;
	sis_ctrl_t        ctrl;
	logic             draining_q;
	logic             drop_q;
	logic             in_xfer;
	logic             out_xfer;
	logic             full;

	assign new_ent.key     = s_axis_tdata[KEY_W-1:0];
	assign new_ent.payload = s_axis_tdata[DATA_W-1:KEY_W];

	assign full          = cell_valid[DEPTH-1];
	assign s_axis_tready = !draining_q;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = draining_q && cell_valid[0];
	assign out_xfer      = m_axis_tvalid && m_axis_tready;
	assign ctrl.insert   = in_xfer && !full;
	assign ctrl.drain    = out_xfer;

	assign m_axis_tdata = {cell_ent[0].payload, cell_ent[0].key};
	assign m_axis_tlast = !cell_valid[1];
	assign m_axis_tuser = drop_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		sis_entry_t left_ent;
		sis_entry_t right_ent;
		logic       left_valid;
		logic       left_moves;
		logic       right_valid;

		if (i == 0) begin : g_head
			assign left_ent   = new_ent;
			assign left_valid = 1'b1;
			assign left_moves = 1'b0;
		end else begin : g_body
			assign left_ent   = cell_ent[i-1];
			assign left_valid = cell_valid[i-1];
			assign left_moves = cell_moves[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_ent   = cell_ent[i];
			assign right_valid = 1'b0;
		end else begin : g_inner
			assign right_ent   = cell_ent[i+1];
			assign right_valid = cell_valid[i+1];
		end

		sis_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.new_ent     (new_ent),
			.left_ent    (left_ent),
			.left_valid  (left_valid),
			.left_moves  (left_moves),
			.right_ent   (right_ent),
			.right_valid (right_valid),
			.ent         (cell_ent[i]),
			.valid       (cell_valid[i]),
			.moves       (cell_moves[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draining_q <= 1'b0;
			drop_q     <= 1'b0;
		end else if (out_xfer && m_axis_tlast) begin
			draining_q <= 1'b0;
			drop_q     <= 1'b0;
		end else if (in_xfer) begin
			draining_q <= s_axis_tlast;
			if (full) begin
				drop_q <= 1'b1;
			end
		end
	end

	`SIS_ASSERT(a_valid_prefix,
		((cell_valid + {{(DEPTH-1){1'b0}}, 1'b1}) & cell_valid) == '0,
		"valid cells do not form a prefix of the chain")
	`SIS_ASSERT(a_drain_nonempty, !draining_q || cell_valid[0],
		"drain running on an empty chain")
	`SIS_ASSERT(a_head_ordered,
		!cell_valid[1] || ($signed(cell_ent[0].key) <= $signed(cell_ent[1].key)),
		"head of the chain is out of order")
	`SIS_ASSERT_NEXT(a_clear_after_final, out_xfer && m_axis_tlast,
		cell_valid == '0 && !drop_q && s_axis_tready,
		"chain not cleared after the final transfer")

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench of stable_insertion_sorter: directed and random sets of
// key/payload pairs are streamed in, and every sorted transfer out is compared with a predictor.
// Depends on sis_pkg and the sorter RTL.
`default_nettype none

module testbench;
	import sis_pkg::*;

	typedef struct {
		logic signed [KEY_W-1:0] key;
		logic [PAYLOAD_W-1:0]    tag;
		logic                    last;
	} sort_pair_t;

	typedef struct {
		logic signed [KEY_W-1:0] key;
		logic [PAYLOAD_W-1:0]    tag;
		logic                    final_item;
		logic                    overflowed;
	} sorted_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [DATA_W-1:0] s_axis_tdata = '0;   // sort_key[31:0], payload[47:32]
	logic              s_axis_tlast = 1'b0;  // end_of_set
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [DATA_W-1:0] m_axis_tdata;        // out_key[31:0], out_payload[47:32]
	logic              m_axis_tlast;        // final_item
	logic              m_axis_tuser;        // overflowed

	stable_insertion_sorter u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sort_pair_t     pending_pairs[$];
	sorted_result_t sorted_expect[$];

	logic signed [KEY_W-1:0] store_key[DEPTH];
	logic [PAYLOAD_W-1:0]    store_tag[DEPTH];
	int                      store_fill = 0;
	logic                    store_dropped = 1'b0;

	int  cyc = 0;
	int  pairs_in = 0;
	int  results_out = 0;
	int  sets_done = 0;
	int  sets_overflowed = 0;
	int  mismatches = 0;
	logic in_taken = 1'b0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	sort_pair_t drv_pair;

	wire quiet = (cyc >= 300) && (cyc < 600);

	task automatic add_pair(input logic signed [KEY_W-1:0] key,
	                        input logic [PAYLOAD_W-1:0] tag, input logic last);
		sort_pair_t p;
		p.key  = key;
		p.tag  = tag;
		p.last = last;
		pending_pairs = {pending_pairs, p};
	endtask

	// Stable insertion: only strictly greater keys move up, so equal keys keep arrival order.
	task automatic insert_and_predict(input sort_pair_t p);
		int pos;
		sorted_result_t r;
		if (store_fill < DEPTH) begin
			pos = store_fill;
			while (pos > 0 && store_key[pos-1] > p.key) begin
				store_key[pos] = store_key[pos-1];
				store_tag[pos] = store_tag[pos-1];
				pos--;
			end
			store_key[pos] = p.key;
			store_tag[pos] = p.tag;
			store_fill++;
		end else begin
			store_dropped = 1'b1;
		end
		if (p.last) begin
			for (int k = 0; k < store_fill; k++) begin
				r.key        = store_key[k];
				r.tag        = store_tag[k];
				r.final_item = (k == store_fill - 1);
				r.overflowed = store_dropped;
				sorted_expect = {sorted_expect, r};
			end
			sets_done++;
			if (store_dropped)
				sets_overflowed++;
			store_fill    = 0;
			store_dropped = 1'b0;
		end
	endtask

	always @(posedge clk) begin
		sort_pair_t     p;
		sorted_result_t e;
		cyc <= cyc + 1;
		in_taken <= s_axis_tvalid && s_axis_tready;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			p.key  = s_axis_tdata[KEY_W-1:0];
			p.tag  = s_axis_tdata[DATA_W-1:KEY_W];
			p.last = s_axis_tlast;
			insert_and_predict(p);
			pairs_in++;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_out++;
			if (sorted_expect.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: key %0d payload %h last %b ovf %b",
						$signed(m_axis_tdata[KEY_W-1:0]), m_axis_tdata[DATA_W-1:KEY_W],
						m_axis_tlast, m_axis_tuser);
			end else begin
				e = sorted_expect.pop_front();
				if (m_axis_tdata[KEY_W-1:0] !== e.key
				    || m_axis_tdata[DATA_W-1:KEY_W] !== e.tag
				    || m_axis_tlast !== e.final_item || m_axis_tuser !== e.overflowed) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Mismatch at result %0d: expected key %0d payload %h last %b ovf %b",
							results_out, e.key, e.tag, e.final_item, e.overflowed);
						$display("  got key %0d payload %h last %b ovf %b",
							$signed(m_axis_tdata[KEY_W-1:0]), m_axis_tdata[DATA_W-1:KEY_W],
							m_axis_tlast, m_axis_tuser);
					end
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (s_axis_tvalid && !in_taken) begin
		end else if (pending_pairs.size() > 0 && (quiet || $urandom_range(99) >= 38)) begin
			drv_pair = pending_pairs.pop_front();
			s_axis_tvalid <= 1'b1;
			s_axis_tdata  <= {drv_pair.tag, drv_pair.key};
			s_axis_tlast  <= drv_pair.last;
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	// The receiver stops once for a long stretch so a drain stalls and the input stalls with it.
	always @(negedge clk) begin
		if (!hold_done && pairs_in >= 150) begin
			hold_left = 300;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= quiet || ($urandom_range(99) >= 38);
		end
	end

	initial begin
		int total;
		int len;
		int mode;
		logic signed [KEY_W-1:0] key;

		add_pair(32'sh7FFFFFFF, 16'h0000, 1'b0);
		add_pair(32'sh80000000, 16'hFFFF, 1'b0);
		add_pair(32'sh00000000, 16'h1234, 1'b0);
		add_pair(-32'sd1, 16'h8000, 1'b1);
		add_pair(32'sd5, 16'hAAAA, 1'b1);
		for (int i = 0; i < 17; i++)
			add_pair((i * 7) % 5 - 2, PAYLOAD_W'(i), i == 16);

		total = 0;
		while (total < 288) begin
			mode = $urandom_range(99);
			if (mode < 8)
				len = $urandom_range(22, 17);
			else if (mode < 18)
				len = DEPTH;
			else if (mode < 28)
				len = 1;
			else
				len = $urandom_range(15, 2);
			mode = $urandom_range(2);
			for (int i = 0; i < len; i++) begin
				if (mode == 0)
					key = $urandom;
				else if (mode == 1)
					key = $signed($urandom_range(6)) - 3;
				else
					key = $urandom_range(1) ? 32'sh80000000 + $urandom_range(3)
					                        : 32'sh7FFFFFFF - $urandom_range(3);
				add_pair(key, PAYLOAD_W'($urandom), i == len - 1);
			end
			total += len;
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_pairs.size() > 0 || s_axis_tvalid || sorted_expect.size() > 0)
			@(posedge clk);
		repeat (2 * DEPTH + 8) @(posedge clk);

		$display("Streamed %0d pairs in %0d sets, %0d of them overflowed;",
			pairs_in, sets_done, sets_overflowed);
		$display("%0d sorted results checked.", results_out);
		if (mismatches == 0 && sorted_expect.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#3000000;
		$display("Timeout with %0d results still expected.", sorted_expect.size());
		$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
